// File: hdl/spxp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the sensor packet XOR parser.
// No dependencies; used by spxp_parse, the top level and spxp_checker.
package spxp_pkg;

    localparam int PhaseW = 5;
    localparam int AccW   = 10;

    localparam logic [PhaseW-1:0] PH_N     = 5'd0;
    localparam logic [PhaseW-1:0] PH_ONE   = 5'd1;
    localparam logic [PhaseW-1:0] PH_COMMA = 5'd2;
    localparam logic [PhaseW-1:0] PH_KIND  = 5'd3;
    localparam logic [PhaseW-1:0] PH_T_EQ  = 5'd4;
    localparam logic [PhaseW-1:0] PH_TEMP  = 5'd5;
    localparam logic [PhaseW-1:0] PH_H     = 5'd6;
    localparam logic [PhaseW-1:0] PH_H_EQ  = 5'd7;
    localparam logic [PhaseW-1:0] PH_HUM   = 5'd8;
    localparam logic [PhaseW-1:0] PH_E_R1  = 5'd9;
    localparam logic [PhaseW-1:0] PH_E_R2  = 5'd10;
    localparam logic [PhaseW-1:0] PH_E_O   = 5'd11;
    localparam logic [PhaseW-1:0] PH_E_R3  = 5'd12;
    localparam logic [PhaseW-1:0] PH_E_EQ  = 5'd13;
    localparam logic [PhaseW-1:0] PH_ERR   = 5'd14;
    localparam logic [PhaseW-1:0] PH_C     = 5'd15;
    localparam logic [PhaseW-1:0] PH_C_EQ  = 5'd16;
    localparam logic [PhaseW-1:0] PH_CSUM  = 5'd17;
    localparam logic [PhaseW-1:0] PH_DONE  = 5'd18;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [AccW-1:0] ACC_MAX  = 10'd1023;
    localparam logic [AccW-1:0] TEMP_MAX = 10'd99;
    localparam logic [AccW-1:0] HUM_MAX  = 10'd100;
    localparam logic [AccW-1:0] CSUM_MAX = 10'd255;
    localparam logic [AccW-1:0] CODE_MIN = 10'd1;
    localparam logic [AccW-1:0] CODE_MAX = 10'd6;

    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic       en;
        logic [7:0] rx_byte;
        logic       packet_end;
    } t_step;

    typedef struct packed {
        logic [1:0] packet_kind;
        logic [6:0] temperature;
        logic [6:0] humidity;
        logic [2:0] error_code;
    } t_result;

endpackage

// File: hdl/spxp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the parser input bytes and results.
// Depends on nothing.
interface spxp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       packet_end;

    modport source (output valid, output rx_byte, output packet_end, input ready);
    modport sink (input valid, input rx_byte, input packet_end, output ready);
endinterface

interface spxp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] packet_kind;
    logic [6:0] temperature;
    logic [6:0] humidity;
    logic [2:0] error_code;

    modport source (output valid, output packet_kind, output temperature,
                    output humidity, output error_code, input ready);
    modport sink (input valid, input packet_kind, input temperature,
                  input humidity, input error_code, output ready);
    modport mon (input valid, input packet_kind, input temperature,
                 input humidity, input error_code, input ready);
endinterface

// File: hdl/spxp_parse.sv
`timescale 1ns / 1ps
// Packet parse state: phase, decimal accumulator, running XOR, held values.
// Depends on spxp_pkg. Gives the packet result for the beat being stepped.
module spxp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spxp_pkg::t_step  i_step,
    output spxp_pkg::t_result o_result
);

    logic [spxp_pkg::PhaseW-1:0] r_phase, n_phase;
    logic [spxp_pkg::AccW-1:0]   r_acc, n_acc;
    logic                        r_seen, n_seen;
    logic [7:0]                  r_xor, n_xor;
    logic [1:0]                  r_fmt, n_fmt;
    logic                        r_fail, n_fail;
    logic [spxp_pkg::AccW-1:0]   r_first, n_first;
    logic [spxp_pkg::AccW-1:0]   r_second, n_second;

    logic [7:0]  w_b;
    logic        w_digit;
    logic        w_comma;
    logic [13:0] w_mac;
    logic [spxp_pkg::AccW-1:0] w_acc_next;
    logic        w_matched;
    logic        w_sum_ok;

    assign w_b     = i_step.rx_byte;
    assign w_digit = (w_b >= spxp_pkg::CH_ZERO) && (w_b <= spxp_pkg::CH_NINE);
    assign w_comma = (w_b == spxp_pkg::CH_COMMA);
    // acc * 10 + digit, saturated
    assign w_mac = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {10'd0, w_b[3:0]};
    assign w_acc_next = (w_mac > {4'd0, spxp_pkg::ACC_MAX}) ? spxp_pkg::ACC_MAX
                                                            : w_mac[spxp_pkg::AccW-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_seen   = r_seen;
        n_xor    = r_xor;
        n_fmt    = r_fmt;
        n_fail   = r_fail;
        n_first  = r_first;
        n_second = r_second;
        o_result = '0;

        if (i_step.en && !r_fail) begin
            if ((r_phase < spxp_pkg::PH_C) &&
                !(((r_phase == spxp_pkg::PH_HUM) || (r_phase == spxp_pkg::PH_ERR)) && w_comma)) begin
                n_xor = r_xor ^ w_b;
            end
            unique case (r_phase)
                spxp_pkg::PH_N: begin
                    if (w_b == spxp_pkg::CH_N) n_phase = spxp_pkg::PH_ONE;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_ONE: begin
                    if (w_b == spxp_pkg::CH_ONE) n_phase = spxp_pkg::PH_COMMA;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_COMMA: begin
                    if (w_comma) n_phase = spxp_pkg::PH_KIND;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_KIND: begin
                    if (w_b == spxp_pkg::CH_T) begin
                        n_fmt   = spxp_pkg::KIND_DATA;
                        n_phase = spxp_pkg::PH_T_EQ;
                    end else if (w_b == spxp_pkg::CH_E) begin
                        n_fmt   = spxp_pkg::KIND_ERR;
                        n_phase = spxp_pkg::PH_E_R1;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                spxp_pkg::PH_T_EQ: begin
                    if (w_b == spxp_pkg::CH_EQ) n_phase = spxp_pkg::PH_TEMP;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_H: begin
                    if (w_b == spxp_pkg::CH_H) n_phase = spxp_pkg::PH_H_EQ;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_H_EQ: begin
                    if (w_b == spxp_pkg::CH_EQ) n_phase = spxp_pkg::PH_HUM;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_E_R1: begin
                    if (w_b == spxp_pkg::CH_R) n_phase = spxp_pkg::PH_E_R2;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_E_R2: begin
                    if (w_b == spxp_pkg::CH_R) n_phase = spxp_pkg::PH_E_O;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_E_O: begin
                    if (w_b == spxp_pkg::CH_O) n_phase = spxp_pkg::PH_E_R3;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_E_R3: begin
                    if (w_b == spxp_pkg::CH_R) n_phase = spxp_pkg::PH_E_EQ;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_E_EQ: begin
                    if (w_b == spxp_pkg::CH_EQ) n_phase = spxp_pkg::PH_ERR;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_TEMP, spxp_pkg::PH_HUM, spxp_pkg::PH_ERR: begin
                    if (w_digit) begin
                        n_acc  = w_acc_next;
                        n_seen = 1'b1;
                    end else if (w_comma && r_seen) begin
                        if (r_phase == spxp_pkg::PH_HUM) n_second = r_acc;
                        else n_first = r_acc;
                        n_acc   = '0;
                        n_seen  = 1'b0;
                        n_phase = (r_phase == spxp_pkg::PH_TEMP) ? spxp_pkg::PH_H
                                                                 : spxp_pkg::PH_C;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                spxp_pkg::PH_C: begin
                    if (w_b == spxp_pkg::CH_C) n_phase = spxp_pkg::PH_C_EQ;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_C_EQ: begin
                    if (w_b == spxp_pkg::CH_EQ) n_phase = spxp_pkg::PH_CSUM;
                    else n_fail = 1'b1;
                end
                spxp_pkg::PH_CSUM: begin
                    if (w_digit) begin
                        n_acc  = w_acc_next;
                        n_seen = 1'b1;
                    end else if (r_seen) begin
                        n_phase = spxp_pkg::PH_DONE;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        w_matched = !n_fail && ((n_phase == spxp_pkg::PH_DONE) ||
                                ((n_phase == spxp_pkg::PH_CSUM) && n_seen));
        w_sum_ok  = (n_acc <= spxp_pkg::CSUM_MAX) && (n_acc[7:0] == n_xor);

        if (w_matched && w_sum_ok) begin
            if (n_fmt == spxp_pkg::KIND_DATA) begin
                if ((n_first <= spxp_pkg::TEMP_MAX) && (n_second <= spxp_pkg::HUM_MAX)) begin
                    o_result.packet_kind = spxp_pkg::KIND_DATA;
                    o_result.temperature = n_first[6:0];
                    o_result.humidity    = n_second[6:0];
                end
            end else if (n_fmt == spxp_pkg::KIND_ERR) begin
                if ((n_first >= spxp_pkg::CODE_MIN) && (n_first <= spxp_pkg::CODE_MAX)) begin
                    o_result.packet_kind = spxp_pkg::KIND_ERR;
                    o_result.error_code  = n_first[2:0];
                end
            end
        end

        // end of packet: back to start
        if (i_step.en && i_step.packet_end) begin
            n_phase  = spxp_pkg::PH_N;
            n_acc    = '0;
            n_seen   = 1'b0;
            n_xor    = '0;
            n_fmt    = spxp_pkg::KIND_NONE;
            n_fail   = 1'b0;
            n_first  = '0;
            n_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= spxp_pkg::PH_N;
            r_acc    <= '0;
            r_seen   <= 1'b0;
            r_xor    <= '0;
            r_fmt    <= spxp_pkg::KIND_NONE;
            r_fail   <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_seen   <= n_seen;
            r_xor    <= n_xor;
            r_fmt    <= n_fmt;
            r_fail   <= n_fail;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

// File: hdl/sensor_packet_xor_parser_top.sv
`timescale 1ns / 1ps
// Top level of the sensor packet XOR parser: input beat register, parser, result register.
// Depends on spxp_pkg, spxp_if and spxp_parse.
//
//  channel | dir | fields                                            | meaning
//  i_rx    | in  | rx_byte[7:0], packet_end                           | packet bytes
//  o_res   | out | packet_kind[1:0], temperature[6:0], humidity[6:0], | one result per packet
//          |     | error_code[2:0]                                    |
//
// One beat per cycle unless o_res stalls; each result is registered after its last beat.
// The input register and the result register advance together whenever the result
// register is empty or being taken, so a stall on o_res holds i_rx.ready low.
// Synchronous active-low reset returns the parser to the start of a packet.
module sensor_packet_xor_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spxp_in_if.sink    i_rx,
    spxp_out_if.source o_res
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_end;
    logic                r_out_valid;
    spxp_pkg::t_result   r_out;
    logic                w_adv;
    spxp_pkg::t_step     w_step;
    spxp_pkg::t_result   w_result;

    assign w_adv = !r_out_valid || o_res.ready;
    assign i_rx.ready = w_adv;

    assign w_step.en         = r_in_valid && w_adv;
    assign w_step.rx_byte    = r_in_byte;
    assign w_step.packet_end = r_in_end;

    spxp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid  <= i_rx.valid;
            r_out_valid <= r_in_valid && r_in_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_end  <= i_rx.packet_end;
            r_out     <= w_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.packet_kind = r_out.packet_kind;
    assign o_res.temperature = r_out.temperature;
    assign o_res.humidity    = r_out.humidity;
    assign o_res.error_code  = r_out.error_code;

endmodule

// File: hdl/spxp_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the parser result channel, bound to the top level.
// Depends on spxp_pkg.
module spxp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_packet_kind,
    input logic [6:0] i_temperature,
    input logic [6:0] i_humidity,
    input logic [2:0] i_error_code
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_packet_kind)
            && $stable(i_temperature) && $stable(i_humidity)
            && $stable(i_error_code))
        else $error("result changed while stalled");

    a_no_res_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");

    a_data_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_packet_kind == spxp_pkg::KIND_DATA) |->
            (i_temperature <= 7'd99) && (i_humidity <= 7'd100)
            && (i_error_code == 3'd0))
        else $error("data result out of range");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_packet_kind == spxp_pkg::KIND_ERR) |->
            (i_error_code >= 3'd1) && (i_error_code <= 3'd6)
            && (i_temperature == 7'd0) && (i_humidity == 7'd0))
        else $error("error result out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_packet_kind != spxp_pkg::KIND_DATA)
            && (i_packet_kind != spxp_pkg::KIND_ERR) |->
            (i_packet_kind == spxp_pkg::KIND_NONE) && (i_temperature == 7'd0)
            && (i_humidity == 7'd0) && (i_error_code == 3'd0))
        else $error("invalid result carries values");

endmodule

bind sensor_packet_xor_parser_top spxp_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_packet_kind (o_res.packet_kind),
    .i_temperature (o_res.temperature),
    .i_humidity    (o_res.humidity),
    .i_error_code  (o_res.error_code)
);
